[rtl/vac_pkg.sv]
// shared types and constants for the vector angle cordic pipeline
// no dependencies; imported by every module of the block
package vac_pkg;

    localparam int IN_W     = 31;
    localparam int OUT_W    = 16;
    localparam int VEC_W    = 63;
    localparam int ANG_W    = 32;
    localparam int SCALE_SH = 30;
    localparam int FRAC_SH  = 16;
    localparam int TABLE_LEN = 32;

    localparam logic signed [ANG_W-1:0] QUARTER_TURN = ANG_W'(9000 * 65536);
    localparam logic signed [OUT_W-1:0] HALF_TURN_HUND    = OUT_W'(18000);
    localparam logic signed [OUT_W-1:0] QUARTER_TURN_HUND = OUT_W'(9000);

    // one item as it moves down the pipeline
    typedef struct packed {
        logic signed [VEC_W-1:0] x;
        logic signed [VEC_W-1:0] y;
        logic signed [ANG_W-1:0] z;
        logic                    special;
        logic signed [OUT_W-1:0] spec_val;
    } t_cordic;

    // atan(2^-i) in hundredths of a degree, 16 fraction bits
    function automatic logic signed [ANG_W-1:0] ang_step(input logic [4:0] idx);
        logic signed [ANG_W-1:0] v;
        begin
            case (idx)
                5'd0:  v = 32'sd294912000;
                5'd1:  v = 32'sd174096719;
                5'd2:  v = 32'sd91987925;
                5'd3:  v = 32'sd46694507;
                5'd4:  v = 32'sd23437865;
                5'd5:  v = 32'sd11730358;
                5'd6:  v = 32'sd5866610;
                5'd7:  v = 32'sd2933484;
                5'd8:  v = 32'sd1466764;
                5'd9:  v = 32'sd733385;
                5'd10: v = 32'sd366693;
                5'd11: v = 32'sd183346;
                5'd12: v = 32'sd91673;
                5'd13: v = 32'sd45837;
                5'd14: v = 32'sd22918;
                5'd15: v = 32'sd11459;
                5'd16: v = 32'sd5730;
                5'd17: v = 32'sd2865;
                5'd18: v = 32'sd1432;
                5'd19: v = 32'sd716;
                5'd20: v = 32'sd358;
                5'd21: v = 32'sd179;
                5'd22: v = 32'sd90;
                5'd23: v = 32'sd45;
                5'd24: v = 32'sd22;
                5'd25: v = 32'sd11;
                5'd26: v = 32'sd6;
                5'd27: v = 32'sd3;
                5'd28: v = 32'sd1;
                5'd29: v = 32'sd1;
                default: v = '0;
            endcase
            return v;
        end
    endfunction

endpackage

[rtl/vac_prerot.sv]
// input stage: special axis cases and quarter-turn pre-rotation into the right half plane
// depends on vac_pkg
module vac_prerot (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    input  logic signed [vac_pkg::IN_W-1:0]  i_x_coord,
    input  logic signed [vac_pkg::IN_W-1:0]  i_y_coord,
    output logic                             o_valid,
    output vac_pkg::t_cordic                 o_data
);
    import vac_pkg::*;

    logic             r_valid;
    t_cordic          r_data;
    t_cordic          n_data;
    logic signed [IN_W:0] x_ext;
    logic signed [IN_W:0] y_ext;
    logic signed [IN_W:0] rx;
    logic signed [IN_W:0] ry;

    always_comb begin
        x_ext = {i_x_coord[IN_W-1], i_x_coord};
        y_ext = {i_y_coord[IN_W-1], i_y_coord};
        n_data = '0;
        rx = x_ext;
        ry = y_ext;
        if (x_ext < 0) begin
            if (y_ext >= 0) begin
                rx = y_ext;
                ry = -x_ext;
                n_data.z = QUARTER_TURN;
            end else begin
                rx = -y_ext;
                ry = x_ext;
                n_data.z = -QUARTER_TURN;
            end
        end
        // scale up so the micro-rotations keep fraction bits
        n_data.x = {{(VEC_W-IN_W-1-SCALE_SH){rx[IN_W]}}, rx, {SCALE_SH{1'b0}}};
        n_data.y = {{(VEC_W-IN_W-1-SCALE_SH){ry[IN_W]}}, ry, {SCALE_SH{1'b0}}};
        if (y_ext == 0) begin
            n_data.special  = 1'b1;
            n_data.spec_val = (x_ext < 0) ? HALF_TURN_HUND : '0;
        end else if (x_ext == 0) begin
            n_data.special  = 1'b1;
            n_data.spec_val = (y_ext > 0) ? QUARTER_TURN_HUND : -QUARTER_TURN_HUND;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_data <= n_data;
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

[rtl/vac_cell.sv]
// one cordic vectoring micro-rotation with a fixed shift
// depends on vac_pkg
module vac_cell #(
    parameter int IDX = 0
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  vac_pkg::t_cordic i_data,
    output logic             o_valid,
    output vac_pkg::t_cordic o_data
);
    import vac_pkg::*;

    localparam logic signed [ANG_W-1:0] STEP = ang_step(5'(IDX));

    logic                    r_valid;
    t_cordic                 r_data;
    t_cordic                 n_data;
    logic signed [VEC_W-1:0] x_in;
    logic signed [VEC_W-1:0] y_in;
    logic signed [VEC_W-1:0] xs;
    logic signed [VEC_W-1:0] ys;

    always_comb begin
        x_in   = i_data.x;
        y_in   = i_data.y;
        xs     = x_in >>> IDX;
        ys     = y_in >>> IDX;
        n_data = i_data;
        // drive y towards zero
        if (y_in > 0) begin
            n_data.x = x_in + ys;
            n_data.y = y_in - xs;
            n_data.z = i_data.z + STEP;
        end else begin
            n_data.x = x_in - ys;
            n_data.y = y_in + xs;
            n_data.z = i_data.z - STEP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_data <= n_data;
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

[rtl/vac_round.sv]
// output stage: round the angle half away from zero, clamp, pick special results
// depends on vac_pkg
module vac_round (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    input  vac_pkg::t_cordic                 i_data,
    output logic                             o_valid,
    output logic signed [vac_pkg::OUT_W-1:0] o_angle_hundredths
);
    import vac_pkg::*;

    logic                    r_valid;
    logic signed [OUT_W-1:0] r_angle;
    logic signed [OUT_W-1:0] n_angle;
    logic signed [ANG_W:0]   z_ext;
    logic signed [ANG_W:0]   z_mag;
    logic        [ANG_W:0]   z_rnd;
    logic signed [ANG_W-FRAC_SH+1:0] r_full;

    always_comb begin
        z_ext = {i_data.z[ANG_W-1], i_data.z};
        z_mag = (z_ext < 0) ? -z_ext : z_ext;
        z_rnd = z_mag + (ANG_W+1)'(32768);
        r_full = {1'b0, z_rnd[ANG_W:FRAC_SH]};
        if (z_ext < 0) begin
            r_full = -r_full;
        end
        if (r_full > 18000) begin
            n_angle = HALF_TURN_HUND;
        end else if (r_full < -18000) begin
            n_angle = -HALF_TURN_HUND;
        end else begin
            n_angle = r_full[OUT_W-1:0];
        end
        if (i_data.special) begin
            n_angle = i_data.spec_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_angle <= n_angle;
    end

    assign o_valid            = r_valid;
    assign o_angle_hundredths = r_angle;

endmodule

[rtl/vector_angle_hundredth_degree_top.sv]
// top level of the vector angle block: pre-rotation, a row of cordic cells, rounding
// depends on vac_pkg, vac_prerot, vac_cell, vac_round
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+--------------------------------
//  request  | in        | start, busy        | i_x_coord, i_y_coord (31b signed)
//  result   | out       | o_valid (1 cycle)  | o_angle_hundredths (16b signed)
//
// one request per cycle; busy is never raised, every cell advances every cycle
// pipeline registers in order: pre-rotation, one cell per micro-rotation, rounding
// each result is shown for exactly one cycle; the receiver cannot stall
// synchronous active-low reset clears only the valid bits of the stages
module vector_angle_hundredth_degree_top #(
    parameter int CORDIC_STAGES = 24
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic signed [vac_pkg::IN_W-1:0]  i_x_coord,
    input  logic signed [vac_pkg::IN_W-1:0]  i_y_coord,
    output logic                             o_valid,
    output logic signed [vac_pkg::OUT_W-1:0] o_angle_hundredths
);
    import vac_pkg::*;

    logic    stage_valid [0:CORDIC_STAGES];
    t_cordic stage_data  [0:CORDIC_STAGES];

    assign busy = 1'b0;

    vac_prerot u_prerot (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (start),
        .i_x_coord (i_x_coord),
        .i_y_coord (i_y_coord),
        .o_valid   (stage_valid[0]),
        .o_data    (stage_data[0])
    );

    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
        vac_cell #(
            .IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (stage_valid[g]),
            .i_data  (stage_data[g]),
            .o_valid (stage_valid[g+1]),
            .o_data  (stage_data[g+1])
        );
    end

    vac_round u_round (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (stage_valid[CORDIC_STAGES]),
        .i_data             (stage_data[CORDIC_STAGES]),
        .o_valid            (o_valid),
        .o_angle_hundredths (o_angle_hundredths)
    );

endmodule
